// ===== src/bsfs_pkg.sv =====
`default_nettype none

package bsfs_pkg;

  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_FLAG    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ADDRESS = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CONTROL = 2'd3;

  localparam logic [7:0] FLAG_RST    = 8'h7E;
  localparam logic [7:0] ESCAPE_RST  = 8'hE0;
  localparam logic [7:0] ADDRESS_RST = 8'hFF;
  localparam logic [7:0] CONTROL_RST = 8'h03;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_FLAG  = 3'd0;
  localparam phase_t PH_ADDR  = 3'd1;
  localparam phase_t PH_CTRL  = 3'd2;
  localparam phase_t PH_ESC   = 3'd3;
  localparam phase_t PH_DATA  = 3'd4;
  localparam phase_t PH_SUM   = 3'd5;
  localparam phase_t PH_CLOSE = 3'd6;

  localparam logic CMD_PAYLOAD = 1'b0;
  localparam logic CMD_END     = 1'b1;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] escape;
    logic [7:0] address;
    logic [7:0] control;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] byte_val;
    logic       last;
    logic       done;
    phase_t     phase_nxt;
    logic       in_frame_nxt;
    logic [7:0] sum_nxt;
  } step_t;

  function automatic logic [7:0] oc_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

`default_nettype wire

// ===== src/bsfs_cfg_regs.sv =====
`default_nettype none

module bsfs_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bsfs_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata,
  output bsfs_pkg::cfg_t                      cfg
);
  import bsfs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag    <= FLAG_RST;
      cfg_r.escape  <= ESCAPE_RST;
      cfg_r.address <= ADDRESS_RST;
      cfg_r.control <= CONTROL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLAG:    cfg_r.flag    <= cfg_wdata;
        REG_ESCAPE:  cfg_r.escape  <= cfg_wdata;
        REG_ADDRESS: cfg_r.address <= cfg_wdata;
        REG_CONTROL: cfg_r.control <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/bsfs_step.sv =====
`default_nettype none

module bsfs_step (
  input  wire bsfs_pkg::cfg_t   cfg,
  input  wire logic             first,
  input  wire bsfs_pkg::phase_t phase_r,
  input  wire logic             cmd,
  input  wire logic [7:0]       data,
  input  wire logic             in_frame,
  input  wire logic [7:0]       sum,
  output bsfs_pkg::step_t       st
);
  import bsfs_pkg::*;

  logic   stuff;
  phase_t body_phase;
  phase_t cur;

  assign stuff = (data == cfg.flag) || (data == cfg.escape);

  always_comb begin
    if (cmd == CMD_END) begin
      body_phase = PH_SUM;
    end else if (stuff) begin
      body_phase = PH_ESC;
    end else begin
      body_phase = PH_DATA;
    end
  end

  assign cur = first ? (in_frame ? body_phase : PH_FLAG) : phase_r;

  always_comb begin
    st              = '0;
    st.phase        = cur;
    st.in_frame_nxt = in_frame;
    st.sum_nxt      = sum;
    st.phase_nxt    = cur;
    unique case (cur)
      PH_FLAG: begin
        st.byte_val  = cfg.flag;
        st.phase_nxt = PH_ADDR;
      end
      PH_ADDR: begin
        st.byte_val  = cfg.address;
        st.phase_nxt = PH_CTRL;
      end
      PH_CTRL: begin
        st.byte_val     = cfg.control;
        st.phase_nxt    = body_phase;
        st.in_frame_nxt = 1'b1;
        st.sum_nxt      = '0;
      end
      PH_ESC: begin
        st.byte_val  = cfg.escape;
        st.phase_nxt = PH_DATA;
        st.sum_nxt   = oc_add(sum, cfg.escape);
      end
      PH_DATA: begin
        st.byte_val = data;
        st.last     = 1'b1;
        st.sum_nxt  = oc_add(sum, data);
      end
      PH_SUM: begin
        st.byte_val  = ~sum;
        st.phase_nxt = PH_CLOSE;
      end
      PH_CLOSE: begin
        st.byte_val     = cfg.flag;
        st.last         = 1'b1;
        st.done         = 1'b1;
        st.in_frame_nxt = 1'b0;
        st.sum_nxt      = '0;
      end
      default: begin
        st.byte_val = '0;
        st.last     = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/byte_stuffing_frame_sender.sv =====
`default_nettype none

// Byte-stuffing frame sender: payload bytes and end-of-frame commands come in on the in_
// stream, framed line bytes leave on the out_ stream at one byte per cycle while out_tready
// is high. The first item of a frame is preceded by flag, address and control bytes; a
// payload byte equal to the flag or escape value goes out behind an escape byte; end of
// frame sends the complemented 8-bit ones' complement sum of the stuffed bytes and then the
// closing flag, marked by out_tuser. out_tlast marks the last byte caused by each input
// beat. An item gives one output byte if plain, two if escaped or for end of frame, plus
// three when it opens a frame. The single output byte register sets this rate; a new beat is
// taken in the cycle its predecessor's last byte is loaded, so single-byte items stream back
// to back. Configuration must be written while idle; the block does not enforce it.
module byte_stuffing_frame_sender (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // data_byte
  input  wire logic [0:0]                     in_tuser,   // command
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata,  // out_byte
  output logic                                out_tlast,
  output logic [0:0]                          out_tuser,  // frame_done
  input  wire logic                           cfg_we,
  input  wire logic [bsfs_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata
);
  import bsfs_pkg::*;

  cfg_t       cfg;
  step_t      st;

  logic       hold_valid_r;
  logic       hold_cmd_r;
  logic [7:0] hold_data_r;
  logic       first_r;
  phase_t     phase_r;
  logic       in_frame_r;
  logic [7:0] sum_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;

  logic       emit;
  logic       in_fire;

  bsfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsfs_step u_step (
    .cfg      (cfg),
    .first    (first_r),
    .phase_r  (phase_r),
    .cmd      (hold_cmd_r),
    .data     (hold_data_r),
    .in_frame (in_frame_r),
    .sum      (sum_r),
    .st       (st)
  );

  assign emit      = hold_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !hold_valid_r || (emit && st.last);
  assign in_fire   = in_tvalid && in_tready;

  // input holding register and per-item sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      first_r      <= 1'b1;
      phase_r      <= PH_FLAG;
      in_frame_r   <= 1'b0;
      sum_r        <= '0;
    end else begin
      if (emit) begin
        in_frame_r <= st.in_frame_nxt;
        sum_r      <= st.sum_nxt;
        phase_r    <= st.phase_nxt;
      end
      if (in_fire) begin
        hold_valid_r <= 1'b1;
        first_r      <= 1'b1;
      end else if (emit) begin
        first_r <= 1'b0;
        if (st.last) begin
          hold_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_cmd_r  <= in_tuser[0];
      hold_data_r <= in_tdata;
    end
  end

  // output byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= st.byte_val;
      out_last_r <= st.last;
      out_done_r <= st.done;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_done_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("closing flag not marked as last byte");

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> hold_valid_r)
    else $error("input stalled with nothing pending");

  a_open_sets_frame: assert property (@(posedge clk) disable iff (!rst_n)
    emit && st.phase == PH_CTRL |=> in_frame_r && sum_r == 8'd0)
    else $error("frame not opened after control byte");

  a_close_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
    emit && st.done |=> !in_frame_r && sum_r == 8'd0)
    else $error("frame still open after closing flag");

  a_flag_only_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
    emit && st.phase == PH_FLAG |-> !in_frame_r)
    else $error("opening flag sent inside an open frame");

endmodule

`default_nettype wire
